/* hdl/rffe_pkg.sv */
// ----------------------------------------------------------------------------
// RFFE master package
// Shared request codes, command opcodes and the per-tick result record.
// ----------------------------------------------------------------------------
package rffe_pkg;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_EXT   = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [2:0] OPC_WRITE = 3'b010;
	localparam logic [2:0] OPC_READ  = 3'b011;
	localparam logic [2:0] OPC_EXT   = 3'b000;

	localparam logic [3:0] CMD_BITS  = 4'd12;
	localparam logic [3:0] BYTE_BITS = 4'd8;

	localparam logic [3:0] SLAVE_RESET = 4'd1;

	localparam logic [1:0] REG_TARGET_ADDR = 2'd0;

	typedef struct packed {
		logic       sdata_out;
		logic       sdata_drive;
		logic       sclk_pulse;
		logic       busy_res;
		logic       sequence_end;
		logic [7:0] read_data;
		logic       read_valid;
		logic       request_ignored;
	} tick_result_t;

endpackage

/* hdl/rffe_seq_core.sv */
// ----------------------------------------------------------------------------
// RFFE bit sequencer core
// Holds the sequence state and works out one bus tick per accepted transaction.
// ----------------------------------------------------------------------------
module rffe_seq_core import rffe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [3:0]   target_id,
	input  logic [1:0]   action,
	input  logic [7:0]   reg_address,
	input  logic [7:0]   write_data,
	input  logic         sdata_in,
	output tick_result_t result
);

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_SSC_HI   = 4'd1,
		PH_SSC_LO   = 4'd2,
		PH_CMD      = 4'd3,
		PH_CMD_PAR  = 4'd4,
		PH_EXT_ADDR = 4'd5,
		PH_EXT_PAR  = 4'd6,
		PH_DATA     = 4'd7,
		PH_DATA_PAR = 4'd8,
		PH_PARK_MID = 4'd9,
		PH_RD_BITS  = 4'd10,
		PH_RD_PAR   = 4'd11,
		PH_PARK_END = 4'd12
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  count_q, count_d;
	logic [11:0] shift_out_q, shift_out_d;
	logic        parity_q, parity_d;
	logic [7:0]  shift_in_q, shift_in_d;
	logic [1:0]  kind_q, kind_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  data_q, data_d;

	logic [3:0]  count_inc;
	logic        out_bit;
	logic [2:0]  opcode;
	logic [4:0]  cmd_addr;

	assign count_inc = count_q + 4'd1;
	assign out_bit   = shift_out_q[11];

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		shift_out_d = shift_out_q;
		parity_d    = parity_q;
		shift_in_d  = shift_in_q;
		kind_d      = kind_q;
		addr_d      = addr_q;
		data_d      = data_q;
		opcode      = OPC_EXT;
		cmd_addr    = 5'd0;

		result                 = '0;
		result.sdata_drive     = 1'b1;
		result.busy_res        = 1'b1;
		result.request_ignored = (action != ACT_NONE);

		case (phase_q)
			PH_SSC_HI: begin
				result.sdata_out = 1'b1;
				phase_d = PH_SSC_LO;
			end
			PH_SSC_LO: begin
				phase_d  = PH_CMD;
				count_d  = 4'd0;
				parity_d = 1'b0;
			end
			PH_CMD, PH_EXT_ADDR, PH_DATA: begin
				result.sdata_out  = out_bit;
				result.sclk_pulse = 1'b1;
				parity_d    = parity_q ^ out_bit;
				shift_out_d = {shift_out_q[10:0], 1'b0};
				count_d     = count_inc;
				if (phase_q == PH_CMD) begin
					if (count_inc >= CMD_BITS) begin
						phase_d = PH_CMD_PAR;
					end
				end else if (count_inc >= BYTE_BITS) begin
					phase_d = (phase_q == PH_EXT_ADDR) ? PH_EXT_PAR : PH_DATA_PAR;
				end
			end
			PH_CMD_PAR, PH_EXT_PAR: begin
				result.sdata_out  = ~parity_q;
				result.sclk_pulse = 1'b1;
				count_d  = 4'd0;
				parity_d = 1'b0;
				if (phase_q == PH_CMD_PAR && kind_q == ACT_EXT) begin
					phase_d     = PH_EXT_ADDR;
					shift_out_d = {addr_q, 4'd0};
				end else if (phase_q == PH_CMD_PAR && kind_q == ACT_READ) begin
					phase_d  = PH_PARK_MID;
					count_d  = count_q;
					parity_d = parity_q;
				end else begin
					phase_d     = PH_DATA;
					shift_out_d = {data_q, 4'd0};
				end
			end
			PH_DATA_PAR: begin
				result.sdata_out  = ~parity_q;
				result.sclk_pulse = 1'b1;
				phase_d = PH_PARK_END;
			end
			PH_PARK_MID: begin
				result.sclk_pulse = 1'b1;
				phase_d    = PH_RD_BITS;
				count_d    = 4'd0;
				shift_in_d = 8'd0;
			end
			PH_RD_BITS: begin
				result.sdata_drive = 1'b0;
				result.sclk_pulse  = 1'b1;
				shift_in_d = {shift_in_q[6:0], sdata_in};
				count_d    = count_inc;
				if (count_inc >= BYTE_BITS) begin
					phase_d = PH_RD_PAR;
				end
			end
			PH_RD_PAR: begin
				result.sdata_drive = 1'b0;
				result.sclk_pulse  = 1'b1;
				phase_d = PH_PARK_END;
			end
			PH_PARK_END: begin
				result.sclk_pulse   = 1'b1;
				result.sequence_end = 1'b1;
				if (kind_q == ACT_READ) begin
					result.read_valid = 1'b1;
					result.read_data  = shift_in_q;
				end
				phase_d = PH_IDLE;
			end
			default: begin
				result.request_ignored = 1'b0;
				phase_d = PH_IDLE;
				if (action == ACT_NONE) begin
					result.busy_res = 1'b0;
				end else begin
					if (action == ACT_WRITE) begin
						opcode = OPC_WRITE;
					end else if (action == ACT_READ) begin
						opcode = OPC_READ;
					end
					if (action != ACT_EXT) begin
						cmd_addr = reg_address[4:0];
					end
					kind_d      = action;
					data_d      = write_data;
					addr_d      = (action == ACT_EXT) ? reg_address : {3'd0, reg_address[4:0]};
					shift_out_d = {target_id, opcode, cmd_addr};
					result.sdata_out = 1'b1;
					phase_d = PH_SSC_LO;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= 4'd0;
			parity_q <= 1'b0;
			kind_q   <= ACT_NONE;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			parity_q <= parity_d;
			kind_q   <= kind_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			shift_out_q <= shift_out_d;
			shift_in_q  <= shift_in_d;
			addr_q      <= addr_d;
			data_q      <= data_d;
		end
	end

endmodule

/* hdl/rffe_master_bit_sequencer.sv */
// ----------------------------------------------------------------------------
// RFFE master bit sequencer
// Serial front-end bus master that emits one bus bit period per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick. When idle, a nonzero action starts
// a register write, extended register write or register read sequence: start
// condition, command frame with parity, data frames, and a final bus park.
// Every input transaction yields exactly one result transaction describing
// the data line level, drive enable and clock pulse for that tick, plus the
// busy, end, read data and dropped-request flags.
// The result appears in the cycle after its input is accepted, and one input
// can be taken in every cycle, so throughput is one tick per clock. The
// single result register sets this figure. The input side stalls only when
// that register is full and the receiver stalls it.
// The slave address register sits at byte address 0 of the APB port and is
// sampled when a sequence starts. Reset returns the sequencer to idle, empties
// the result register and sets the slave address to 1.
// ----------------------------------------------------------------------------
module rffe_master_bit_sequencer import rffe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  reg_address,
	input  logic [7:0]  write_data,
	input  logic        sdata_in,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        sdata_out,
	output logic        sdata_drive,
	output logic        sclk_pulse,
	output logic        busy_res,
	output logic        sequence_end,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic        request_ignored
);

	logic [3:0]   slave_q;
	logic         out_valid_q;
	tick_result_t result;
	tick_result_t result_q;
	logic         step;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_TARGET_ADDR) ? {28'd0, slave_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= SLAVE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			slave_q <= pwdata[3:0];
		end
	end

	assign in_stall = out_valid_q & out_stall;
	assign step     = in_valid & ~in_stall;

	rffe_seq_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.target_id     (slave_q),
		.action        (action),
		.reg_address   (reg_address),
		.write_data    (write_data),
		.sdata_in      (sdata_in),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= step | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign sdata_out       = result_q.sdata_out;
	assign sdata_drive     = result_q.sdata_drive;
	assign sclk_pulse      = result_q.sclk_pulse;
	assign busy_res        = result_q.busy_res;
	assign sequence_end    = result_q.sequence_end;
	assign read_data       = result_q.read_data;
	assign read_valid      = result_q.read_valid;
	assign request_ignored = result_q.request_ignored;

endmodule
